[rtl/cpilf_pkg.sv]
package cpilf_pkg;

  // Stream widths, padded to whole bytes
  localparam int IN_W  = 40;
  localparam int OUT_W = 56;

  // Input item layout
  localparam int IN_MODE_LO = 0;
  localparam int IN_ERR_LO  = 2;
  localparam int IN_AMP_LO  = 18;

  // Result item layout
  localparam int OUT_CMD_LO    = 0;
  localparam int OUT_TICK_LO   = 16;
  localparam int OUT_FROZEN_BIT = 48;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Amplitude window, Q2.14: 0.01 and 2.0
  localparam logic [15:0] AMP_MIN = 16'd164;
  localparam logic [15:0] AMP_MAX = 16'd32768;

  // Gain fraction bits (Q4.12)
  localparam logic [4:0] GAIN_FRAC = 5'd12;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ADAPT_A = 2'd1,
    MODE_ADAPT_B = 2'd2,
    MODE_HOLD    = 2'd3
  } run_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN       = 4'd0,
    REG_INT_GAIN_DT     = 4'd1,
    REG_PHASE_LIMIT     = 4'd2,
    REG_STEP_SHIFT      = 4'd3,
    REG_LOOP_ENABLE     = 4'd4,
    REG_WINDUP_GUARD    = 4'd5,
    REG_FREEZE_ON_FAULT = 4'd6,
    REG_START_PHASE     = 4'd7
  } cfg_reg_t;

endpackage

[rtl/cdr_pi_loop_filter_core.sv]
// PI phase loop filter for a CDR loop, with command clamp, anti-windup,
// quantization and sticky fault freeze.
//
// s_* : one update tick per item. s_tdata = run_mode, phase err, amplitude.
// m_* : one result per tick: phase_command, tick_count, frozen.
// cfg : register writes (index, data); always ready. Write only while idle.
//
// One item per cycle unless m_tready stalls. Stages: input register, product
// register, result register; m_tvalid rises as an item enters the last. The
// two gain multiplies sit in the second stage; the integrator, clamp and
// rounding update runs in the last stage, so the loop state closes in it.
//
// Reset (rst, synchronous) loads the register defaults, clears integrator,
// tick counter and freeze flag, sets the command to zero and empties
// the pipeline. When m_tready is low the result register holds; stages behind
// it keep filling until each holds an item, then s_tready drops.
module cdr_pi_loop_filter_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [1:0] run_mode, [17:2] phase err, [33:18] amplitude, rest zero
  input  logic [cpilf_pkg::IN_W-1:0]         s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [15:0] phase_command, [47:16] tick_count, [48] frozen, rest zero
  output logic [cpilf_pkg::OUT_W-1:0]        m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cpilf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpilf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cpilf_pkg::*;

  // Configuration
  logic [15:0]        prop_gain;
  logic [15:0]        int_gain_dt;
  logic [14:0]        phase_limit;
  logic [3:0]         step_shift;
  logic               loop_enable;
  logic               windup_guard;
  logic               freeze_on_fault;

  // Loop state
  logic signed [31:0] integrator;
  logic signed [15:0] command_reg;
  logic               freeze_reg;
  logic [31:0]        tick_counter;

  // Pipeline
  logic               v1, v2, v3;
  logic               en1, en2, en3;
  run_mode_t          mode1;
  logic signed [15:0] err1;
  logic [15:0]        amp1;

  logic               go2, fault2, upd2;
  logic signed [32:0] p2, di2;

  logic signed [15:0] cmd3;
  logic [31:0]        tick3;
  logic               frozen3;

  // Stage 2 combinational
  logic signed [32:0] p_prod, di_prod;
  logic signed [16:0] err_ext;
  logic [16:0]        err_mag;
  logic               fault_seen;

  // Stage 3 combinational
  logic               step;
  logic signed [33:0] sum_i;
  logic signed [31:0] cand;
  logic signed [34:0] cmd_raw, bound;
  logic               clamped, neg;
  logic [26:0]        cmd_mag;
  logic [4:0]         sh;
  logic [27:0]        half, rnd, q, rq;
  logic signed [15:0] cmd_q;
  logic signed [31:0] integrator_next;
  logic signed [15:0] command_next;
  logic               freeze_next;
  logic [31:0]        tick_next;

  assign cfg_ready = 1'b1;

  assign en3      = !v3 || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign step     = en3 && v2;

  assign m_tvalid = v3;
  assign m_tdata  = {7'd0, frozen3, tick3, cmd3};

  // ---- stage 2: products and fault check ----
  assign p_prod  = $signed({1'b0, prop_gain}) * err1;
  assign di_prod = $signed({1'b0, int_gain_dt}) * err1;
  assign err_ext = {err1[15], err1};
  assign err_mag = err1[15] ? 17'(-err_ext) : 17'(err_ext);
  assign fault_seen = (amp1 < AMP_MIN) || (amp1 > AMP_MAX) ||
                      (err_mag > {1'b0, phase_limit, 1'b0});

  // ---- stage 3: loop update ----
  always_comb begin
    sum_i = $signed({{2{integrator[31]}}, integrator}) + $signed({di2[32], di2});
    if (sum_i[33:31] == 3'b000 || sum_i[33:31] == 3'b111) begin
      cand = sum_i[31:0];
    end else if (sum_i[33]) begin
      cand = 32'sh8000_0000;
    end else begin
      cand = 32'sh7fff_ffff;
    end

    cmd_raw = $signed({{3{cand[31]}}, cand}) + $signed({{2{p2[32]}}, p2});
    bound   = $signed({8'd0, phase_limit, 12'd0});
    clamped = (cmd_raw > bound) || (cmd_raw < -bound);
    neg     = cmd_raw[34];
    if (clamped) begin
      cmd_mag = {phase_limit, 12'd0};
    end else if (neg) begin
      cmd_mag = 27'(-cmd_raw);
    end else begin
      cmd_mag = cmd_raw[26:0];
    end

    // round half away from zero to a multiple of 2^step_shift
    sh   = GAIN_FRAC + {1'b0, step_shift};
    half = 28'd1 << (sh - 5'd1);
    rnd  = {1'b0, cmd_mag} + half;
    q    = rnd >> sh;
    rq   = q << step_shift;
    if (neg) begin
      cmd_q = (rq > 28'd32768) ? 16'sh8000 : 16'(28'd0 - rq);
    end else begin
      cmd_q = (rq > 28'd32767) ? 16'sh7fff : rq[15:0];
    end

    integrator_next = integrator;
    command_next    = command_reg;
    freeze_next     = freeze_reg;
    tick_next       = tick_counter;
    if (go2 && !freeze_reg) begin
      if (fault2) begin
        freeze_next = 1'b1;
      end else begin
        if (upd2) begin
          command_next = cmd_q;
          if (!(clamped && windup_guard)) begin
            integrator_next = cand;
          end
        end
        tick_next = tick_counter + 32'd1;
      end
    end
  end

  // ---- pipeline valids ----
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // ---- pipeline payload ----
  always_ff @(posedge clk) begin
    if (en1 && s_tvalid) begin
      mode1 <= run_mode_t'(s_tdata[IN_MODE_LO +: 2]);
      err1  <= s_tdata[IN_ERR_LO +: 16];
      amp1  <= s_tdata[IN_AMP_LO +: 16];
    end
    if (en2 && v1) begin
      go2    <= (mode1 != MODE_HOLD);
      fault2 <= freeze_on_fault && fault_seen;
      upd2   <= loop_enable && (mode1 == MODE_ADAPT_A || mode1 == MODE_ADAPT_B);
      p2     <= p_prod;
      di2    <= di_prod;
    end
    if (step) begin
      cmd3    <= command_next;
      tick3   <= tick_next;
      frozen3 <= freeze_next;
    end
  end

  // ---- loop state and configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= 16'd4096;
      int_gain_dt     <= 16'd64;
      phase_limit     <= 15'd16384;
      step_shift      <= 4'd6;
      loop_enable     <= 1'b1;
      windup_guard    <= 1'b1;
      freeze_on_fault <= 1'b1;
      integrator      <= 32'sd0;
      command_reg     <= 16'sd0;
      freeze_reg      <= 1'b0;
      tick_counter    <= 32'd0;
    end else begin
      if (step) begin
        integrator   <= integrator_next;
        command_reg  <= command_next;
        freeze_reg   <= freeze_next;
        tick_counter <= tick_next;
      end
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_PROP_GAIN:       prop_gain       <= cfg_data;
          REG_INT_GAIN_DT:     int_gain_dt     <= cfg_data;
          REG_PHASE_LIMIT:     phase_limit     <= cfg_data[14:0];
          REG_STEP_SHIFT:      step_shift      <= cfg_data[3:0];
          REG_LOOP_ENABLE:     loop_enable     <= cfg_data[0];
          REG_WINDUP_GUARD:    windup_guard    <= cfg_data[0];
          REG_FREEZE_ON_FAULT: freeze_on_fault <= cfg_data[0];
          REG_START_PHASE: begin
            // start_phase presets the live command
            command_reg <= cfg_data;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

[rtl/cpilf_checker.sv]
module cpilf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [cpilf_pkg::OUT_W-1:0] m_tdata
);
  import cpilf_pkg::*;

  logic        frozen_bit;
  logic [31:0] tick_f;
  logic [15:0] cmd_f;

  assign frozen_bit = m_tdata[OUT_FROZEN_BIT];
  assign tick_f     = m_tdata[OUT_TICK_LO +: 32];
  assign cmd_f      = m_tdata[OUT_CMD_LO +: 16];

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // freeze is sticky until reset
  a_freeze_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && frozen_bit |=> !m_tvalid || frozen_bit)
    else $error("freeze flag cleared without reset");

  // frozen loop neither counts ticks nor moves the command
  a_frozen_still: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && frozen_bit |=>
      !m_tvalid || (tick_f == $past(tick_f) && cmd_f == $past(cmd_f)))
    else $error("state moved while frozen");

endmodule

bind cdr_pi_loop_filter_core cpilf_checker u_cpilf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[bench/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cpilf_pkg::*;

  typedef struct packed {
    run_mode_t   mode;
    logic [15:0] err;
    logic [15:0] amp;
  } tick_t;

  typedef struct packed {
    logic [15:0] cmd;
    logic [31:0] ticks;
    logic        frozen;
  } lf_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cdr_pi_loop_filter_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Filter settings and state as the predictor sees them
  logic [15:0]        kp, ki;
  logic [14:0]        limit;
  logic [3:0]         shift;
  logic               loop_en, guard, freeze_en;
  int                 integ_acc;
  logic [15:0]        cmd_reg;
  logic               frozen_exp;
  logic [31:0]        tick_total;

  tick_t      tick_q[$];
  lf_result_t cmd_expect_q[$];
  int         mismatch_count = 0;

  // Stimulus pacing
  bit          steady_send = 1'b1;
  logic [15:0] ready_pat = 16'hFFFF;
  logic [3:0]  pat_pos = '0;
  int          burst_left = 1;
  int          gap_left = 0;
  bit          item_taken = 1'b0;

  function automatic void advance_loop_filter(input tick_t t);
    int         e, sh;
    longint     p, cand, sum, bound, mag, q, r;
    lf_result_t res;
    e = $signed(t.err);
    if (t.mode != MODE_HOLD && !frozen_exp) begin
      if (freeze_en && (t.amp < AMP_MIN || t.amp > AMP_MAX ||
                        (e < 0 ? -e : e) > 2 * int'(limit))) begin
        frozen_exp = 1'b1;
      end else begin
        if (loop_en && (t.mode == MODE_ADAPT_A || t.mode == MODE_ADAPT_B)) begin
          p = longint'(kp) * longint'(e);
          cand = longint'(integ_acc) + longint'(ki) * longint'(e);
          if (cand > 64'sd2147483647) cand = 64'sd2147483647;
          else if (cand < -64'sd2147483648) cand = -64'sd2147483648;
          sum = p + cand;
          bound = longint'(limit) * 4096;
          if (sum > bound || sum < -bound) begin
            sum = (sum > 0) ? bound : -bound;
            if (!guard) integ_acc = int'(cand);
          end else begin
            integ_acc = int'(cand);
          end
          // round half away from zero on the magnitude, then requantize
          sh = 12 + int'(shift);
          mag = (sum < 0) ? -sum : sum;
          q = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
          r = q <<< shift;
          if (sum < 0) r = -r;
          if (r > 32767) r = 32767;
          else if (r < -32768) r = -32768;
          cmd_reg = r[15:0];
        end
        tick_total = tick_total + 1;
      end
    end
    res.cmd = cmd_reg;
    res.ticks = tick_total;
    res.frozen = frozen_exp;
    cmd_expect_q = {cmd_expect_q, res};
  endfunction

  function automatic int unsigned pick_value(input int unsigned hi);
    case ($urandom_range(0, 4))
      0: return 0;
      1: return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // safe keeps the item clear of the fault window
  function automatic tick_t rand_tick(input bit safe, input int bias);
    tick_t t;
    int    e, m;
    case ($urandom_range(0, 9))
      7: t.mode = MODE_IDLE;
      8: t.mode = MODE_HOLD;
      9: t.mode = run_mode_t'($urandom_range(0, 3));
      default: t.mode = $urandom_range(0, 1) ? MODE_ADAPT_B : MODE_ADAPT_A;
    endcase
    case ($urandom_range(0, 5))
      0: e = int'($urandom_range(0, 65535)) - 32768;
      1: e = $urandom_range(0, 1) ? 32767 : -32768;
      default: e = bias + int'($urandom_range(0, 1023)) - 512;
    endcase
    if (safe) begin
      m = 2 * int'(limit);
      if (e > m) e = m;
      if (e < -m) e = -m;
    end
    if (e > 32767) e = 32767;
    if (e < -32768) e = -32768;
    t.err = e[15:0];
    if (safe || $urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 9))
        0: t.amp = AMP_MIN;
        1: t.amp = AMP_MAX;
        default: t.amp = 16'($urandom_range(int'(AMP_MIN), int'(AMP_MAX)));
      endcase
    end else begin
      t.amp = 16'($urandom_range(0, 65535));
    end
    return t;
  endfunction

  task automatic queue_tick(input run_mode_t m, input logic [15:0] e, input logic [15:0] a);
    tick_t t;
    t.mode = m;
    t.err = e;
    t.amp = a;
    tick_q = {tick_q, t};
  endtask

  // cfg_valid stays high across back-to-back writes; end_writes drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_PROP_GAIN:       kp = val;
      REG_INT_GAIN_DT:     ki = val;
      REG_PHASE_LIMIT:     limit = val[14:0];
      REG_STEP_SHIFT:      shift = val[3:0];
      REG_LOOP_ENABLE:     loop_en = val[0];
      REG_WINDUP_GUARD:    guard = val[0];
      REG_FREEZE_ON_FAULT: freeze_en = val[0];
      REG_START_PHASE: begin
        cmd_reg = val;
      end
      default: ;
    endcase
  endtask

  task automatic end_writes;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle;
    while (tick_q.size() != 0 || cmd_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pacing(input bit calm);
    @(posedge clk);
    steady_send = calm || ($urandom_range(0, 3) == 0);
    ready_pat = (calm || $urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
  endtask

  // Sender: bursts of items with random gaps, or back to back when steady_send
  always @(negedge clk) begin
    if (s_tvalid && !item_taken) begin
      // item still waiting for s_tready
    end else if (gap_left > 0 && !steady_send) begin
      gap_left--;
      s_tvalid <= 1'b0;
    end else if (tick_q.size() > 0) begin
      s_tvalid <= 1'b1;
      s_tdata  <= {{(IN_W - 34){1'b0}}, tick_q[0].amp, tick_q[0].err, tick_q[0].mode};
      if (!steady_send) begin
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = $urandom_range(1, 9);
        end else begin
          burst_left--;
        end
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Receiver: stall pattern rotating per cycle
  always @(negedge clk) begin
    m_tready <= ready_pat[pat_pos];
    pat_pos <= pat_pos + 1'b1;
  end

  // Check results first, then take in the item accepted at this edge
  always @(posedge clk) begin : monitor
    lf_result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (cmd_expect_q.size() == 0) begin
        if (mismatch_count < 10) $display("result with nothing expected: %h", m_tdata);
        mismatch_count++;
      end else begin
        want = cmd_expect_q.pop_front();
        if (m_tdata[OUT_CMD_LO +: 16] !== want.cmd ||
            m_tdata[OUT_TICK_LO +: 32] !== want.ticks ||
            m_tdata[OUT_FROZEN_BIT] !== want.frozen) begin
          if (mismatch_count < 10)
            $display("mismatch: exp cmd %h ticks %h frozen %b, got cmd %h ticks %h frozen %b",
                     want.cmd, want.ticks, want.frozen, m_tdata[OUT_CMD_LO +: 16],
                     m_tdata[OUT_TICK_LO +: 32], m_tdata[OUT_FROZEN_BIT]);
          mismatch_count++;
        end
      end
    end
    item_taken = (s_tvalid === 1'b1 && s_tready === 1'b1);
    if (!rst && item_taken) advance_loop_filter(tick_q.pop_front());
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int  ph, n, bias;
    bit  ff_on;
    kp = 16'd4096;
    ki = 16'd64;
    limit = 15'd16384;
    shift = 4'd6;
    loop_en = 1'b1;
    guard = 1'b1;
    freeze_en = 1'b1;
    integ_acc = 0;
    cmd_reg = '0;
    frozen_exp = 1'b0;
    tick_total = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings, every mode, field extremes at the fault edges
    set_pacing(1'b1);
    queue_tick(MODE_IDLE, 16'sd100, 16'd16384);
    queue_tick(MODE_HOLD, 16'sd5000, 16'd0);
    queue_tick(MODE_ADAPT_A, 16'sd1000, 16'd16384);
    queue_tick(MODE_ADAPT_B, -16'sd1000, 16'd16384);
    queue_tick(MODE_ADAPT_A, 16'h7FFF, AMP_MIN);
    queue_tick(MODE_ADAPT_B, 16'h8000, AMP_MAX);
    queue_tick(MODE_ADAPT_A, 16'h0000, 16'd8192);
    wait_idle();

    // widest clamp: rounding runs past the top of the command range
    write_reg(REG_PHASE_LIMIT, 16'h7FFF);
    end_writes();
    set_pacing(1'b1);
    queue_tick(MODE_ADAPT_A, 16'h7FFF, 16'd16384);
    queue_tick(MODE_ADAPT_B, 16'h8000, 16'd16384);
    wait_idle();

    // preset load, coarsest step, loop disabled
    write_reg(REG_STEP_SHIFT, 16'd15);
    write_reg(REG_START_PHASE, 16'h8000);
    write_reg(REG_LOOP_ENABLE, 16'd0);
    end_writes();
    set_pacing(1'b0);
    queue_tick(MODE_ADAPT_A, 16'sd1234, 16'd16384);
    queue_tick(MODE_ADAPT_B, -16'sd1234, 16'd16384);
    wait_idle();

    // max gains, finest step, no windup guard, faults ignored, bad index
    write_reg(REG_LOOP_ENABLE, 16'd1);
    write_reg(REG_STEP_SHIFT, 16'd0);
    write_reg(REG_PROP_GAIN, 16'hFFFF);
    write_reg(REG_INT_GAIN_DT, 16'hFFFF);
    write_reg(REG_WINDUP_GUARD, 16'd0);
    write_reg(REG_FREEZE_ON_FAULT, 16'd0);
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_START_PHASE) + 1, (1 << CFG_IDX_W) - 1)),
              16'($urandom));
    write_reg(REG_START_PHASE, 16'h7FFF);
    end_writes();
    set_pacing(1'b0);
    queue_tick(MODE_ADAPT_A, 16'h7FFF, 16'd0);
    queue_tick(MODE_ADAPT_B, 16'h8000, 16'hFFFF);
    queue_tick(MODE_ADAPT_A, 16'sd3, AMP_MIN - 16'd1);
    queue_tick(MODE_ADAPT_B, -16'sd3, AMP_MAX + 16'd1);
    queue_tick(MODE_ADAPT_A, 16'h8000, 16'd0);
    queue_tick(MODE_IDLE, 16'h7FFF, 16'hFFFF);
    wait_idle();

    // Random settings per phase; freeze only armed with in-window items
    for (ph = 0; ph < 12; ph++) begin
      ff_on = ($urandom_range(0, 2) == 0);
      bias = int'($urandom_range(0, 8000)) - 4000;
      write_reg(REG_PROP_GAIN, 16'(pick_value(65535)));
      write_reg(REG_INT_GAIN_DT, 16'(pick_value(65535)));
      write_reg(REG_PHASE_LIMIT, 16'(pick_value(32767)));
      write_reg(REG_STEP_SHIFT, 16'(pick_value(15)));
      write_reg(REG_LOOP_ENABLE, 16'($urandom_range(0, 3) != 0));
      write_reg(REG_WINDUP_GUARD, 16'($urandom_range(0, 1)));
      write_reg(REG_FREEZE_ON_FAULT, 16'(ff_on));
      if ($urandom_range(0, 2) == 0) write_reg(REG_START_PHASE, 16'($urandom));
      end_writes();
      set_pacing(1'b0);
      for (n = 0; n < 115; n++) tick_q = {tick_q, rand_tick(ff_on, bias)};
      wait_idle();
    end

    // Faults armed with unrestricted items: freezes, then stays frozen
    write_reg(REG_FREEZE_ON_FAULT, 16'd1);
    write_reg(REG_PHASE_LIMIT, 16'(pick_value(32767)));
    end_writes();
    set_pacing(1'b0);
    bias = int'($urandom_range(0, 8000)) - 4000;
    for (n = 0; n < 60; n++) tick_q = {tick_q, rand_tick(1'b0, bias)};
    wait_idle();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
